@@ sv/sorted_key_value_table_macros.svh @@
// Assertion macros for the sorted key/value table.
`ifndef SORTED_KEY_VALUE_TABLE_MACROS_SVH
`define SORTED_KEY_VALUE_TABLE_MACROS_SVH

// Clocked check, disabled while reset is high.
`define SKVT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication check: cause in this cycle, effect in the next.
`define SKVT_ASSERT_NEXT(label, clk, rst, cause, effect, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) else $error(msg);

`endif

@@ sv/skvt_pkg.sv @@
// Types and constants shared by the sorted key/value table modules.
package skvt_pkg;

   localparam int DEPTH      = 64;
   localparam int KEY_BITS   = 16;
   localparam int VALUE_BITS = 8;
   localparam int FUNC_BITS  = 3;
   localparam int STAT_BITS  = 3;
   localparam int IDX_BITS   = $clog2(DEPTH);
   localparam int POS_BITS   = $clog2(DEPTH + 1);

   localparam int REQ_BITS       = FUNC_BITS + KEY_BITS + VALUE_BITS + IDX_BITS;
   localparam int REQ_TDATA_BITS = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS       = STAT_BITS + POS_BITS + KEY_BITS + VALUE_BITS + POS_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [FUNC_BITS-1:0] {
      FN_LOOKUP = 3'd0,
      FN_UPDATE = 3'd1,
      FN_INSERT = 3'd2,
      FN_DELETE = 3'd3,
      FN_READ   = 3'd4
   } func_type;

   typedef enum logic [STAT_BITS-1:0] {
      ST_OK        = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_PRESENT   = 3'd2,
      ST_FULL      = 3'd3,
      ST_RANGE     = 3'd4
   } status_type;

   // Broadcast to every cell when a request is taken.
   typedef struct packed {
      logic                load;
      logic                is_read;
      logic [KEY_BITS-1:0] key;
      logic [IDX_BITS-1:0] index;
      logic [POS_BITS-1:0] count;
   } cell_accept_type;

   // Broadcast to every cell in the execute cycle.
   typedef struct packed {
      logic                  shift_up;
      logic                  shift_down;
      logic                  write_value;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } cell_cmd_type;

   // Per-cell match flags.
   typedef struct packed {
      logic at;    // first slot whose key is not below the search key
      logic hit;   // at, and the key matches
      logic pick;  // hit, or the slot addressed by a read
   } cell_flags_type;

endpackage

@@ sv/skvt_cell.sv @@
// One table slot: key/value storage, compare flags and neighbour shift.
module skvt_cell (
   input  logic                           clock,
   input  logic [skvt_pkg::IDX_BITS-1:0]   cell_index,
   input  skvt_pkg::cell_accept_type      acc,
   input  skvt_pkg::cell_cmd_type         cmd,
   input  logic                           left_lt,
   input  logic [skvt_pkg::KEY_BITS-1:0]   left_key,
   input  logic [skvt_pkg::VALUE_BITS-1:0] left_value,
   input  logic [skvt_pkg::KEY_BITS-1:0]   right_key,
   input  logic [skvt_pkg::VALUE_BITS-1:0] right_value,
   output logic                           lt,
   output logic [skvt_pkg::KEY_BITS-1:0]   key,
   output logic [skvt_pkg::VALUE_BITS-1:0] value,
   output skvt_pkg::cell_flags_type       flags
);
   import skvt_pkg::*;

   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  lt_ff, eq_ff, sel_ff;
   logic                  occupied;
   logic                  at;

   assign occupied = POS_BITS'(cell_index) < acc.count;
   assign at       = left_lt && !lt_ff;

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      priority if (cmd.write_value && at && eq_ff) begin
         value_in = cmd.value;
      end else if (cmd.shift_up && !lt_ff) begin
         key_in   = at ? cmd.key : left_key;
         value_in = at ? cmd.value : left_value;
      end else if (cmd.shift_down && !lt_ff) begin
         key_in   = right_key;
         value_in = right_value;
      end else begin
         key_in   = key_ff;
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      if (acc.load) begin
         lt_ff  <= occupied && (key_ff < acc.key);
         eq_ff  <= occupied && (key_ff == acc.key) && !acc.is_read;
         sel_ff <= occupied && acc.is_read && (cell_index == acc.index);
      end
   end

   assign lt         = lt_ff;
   assign key        = key_ff;
   assign value      = value_ff;
   assign flags.at   = at;
   assign flags.hit  = at && eq_ff;
   assign flags.pick = (at && eq_ff) || sel_ff;

endmodule

@@ sv/skvt_collect.sv @@
// Gathers the cell flags into hit, position and the picked entry.
module skvt_collect (
   input  skvt_pkg::cell_flags_type       flags [skvt_pkg::DEPTH],
   input  logic [skvt_pkg::KEY_BITS-1:0]   keys  [skvt_pkg::DEPTH],
   input  logic [skvt_pkg::VALUE_BITS-1:0] values [skvt_pkg::DEPTH],
   input  logic                           last_lt,
   output logic                           hit,
   output logic [skvt_pkg::POS_BITS-1:0]   position,
   output logic [skvt_pkg::KEY_BITS-1:0]   pick_key,
   output logic [skvt_pkg::VALUE_BITS-1:0] pick_value
);
   import skvt_pkg::*;

   always_comb begin
      hit        = 1'b0;
      position   = '0;
      pick_key   = '0;
      pick_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         hit = hit | flags[i].hit;
         if (flags[i].at) begin
            position = position | POS_BITS'(i);
         end
         if (flags[i].pick) begin
            pick_key   = pick_key | keys[i];
            pick_value = pick_value | values[i];
         end
      end
      // every slot holds a smaller key: insertion point is past the end
      if (last_lt) begin
         position = POS_BITS'(DEPTH);
      end
   end

endmodule

@@ sv/sorted_key_value_table.sv @@
// Top level of the sorted key/value table.
//
// Keeps up to DEPTH key/value entries in ascending key order in a row of
// cells. Requests arrive on req_ (func, key, value, index); each gives one
// response on rsp_ (status, position, out_key, out_value, count).
// Functions: lookup, update value, ordered insert, delete, read at index.
// A failing request leaves the table unchanged and reports a status code.
//
// Timing: a request is taken in idle; at that edge every cell compares its
// key with the broadcast key. In the execute state the flags are combined,
// the cells shift or rewrite in place and the response is registered, once
// the output register is free. rsp_tvalid is set at that execute edge; no new
// request is taken until the one before it has executed.
//
// Reset empties the table (count zero) and drops any pending response.
// If the response is not taken, the block still takes one more request,
// then holds it in the execute cycle until the output register is free.
`include "sorted_key_value_table_macros.svh"

module sorted_key_value_table (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // func[2:0], key, value, index, zero padding
   input  logic [skvt_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // status[2:0], position, out_key, out_value, count, zero padding
   output logic [skvt_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata
);
   import skvt_pkg::*;

   typedef enum logic {S_IDLE, S_EXEC} state_type;

   localparam int KEY_LO = FUNC_BITS;
   localparam int VAL_LO = KEY_LO + KEY_BITS;
   localparam int IDX_LO = VAL_LO + VALUE_BITS;

   state_type             state_ff;
   func_type              func_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic [IDX_BITS-1:0]   index_ff;
   logic [POS_BITS-1:0]   count_ff, count_in;

   logic                  rsp_valid_ff;
   status_type            status_ff, status_in;
   logic [POS_BITS-1:0]   position_ff, position_in;
   logic [KEY_BITS-1:0]   out_key_ff, out_key_in;
   logic [VALUE_BITS-1:0] out_value_ff, out_value_in;

   logic                  req_take;
   logic                  do_exec;
   logic                  full;
   logic                  read_ok;
   logic                  shift_up, shift_down, write_value;

   cell_accept_type       acc;
   cell_cmd_type          cmd;
   cell_flags_type        flags  [DEPTH];
   logic [KEY_BITS-1:0]   keys   [DEPTH];
   logic [VALUE_BITS-1:0] values [DEPTH];
   logic                  lts    [DEPTH];

   logic                  hit;
   logic [POS_BITS-1:0]   position;
   logic [KEY_BITS-1:0]   pick_key;
   logic [VALUE_BITS-1:0] pick_value;

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign do_exec    = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);

   assign acc.load    = req_take;
   assign acc.is_read = (req_tdata[FUNC_BITS-1:0] == FN_READ);
   assign acc.key     = req_tdata[KEY_LO +: KEY_BITS];
   assign acc.index   = req_tdata[IDX_LO +: IDX_BITS];
   assign acc.count   = count_ff;

   assign full    = (count_ff == POS_BITS'(DEPTH));
   assign read_ok = (POS_BITS'(index_ff) < count_ff);

   assign shift_up    = do_exec && (func_ff == FN_INSERT) && !hit && !full;
   assign shift_down  = do_exec && (func_ff == FN_DELETE) && hit;
   assign write_value = do_exec && (func_ff == FN_UPDATE) && hit;

   assign cmd.shift_up    = shift_up;
   assign cmd.shift_down  = shift_down;
   assign cmd.write_value = write_value;
   assign cmd.key         = key_ff;
   assign cmd.value       = value_ff;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic                  left_lt;
      logic [KEY_BITS-1:0]   left_key, right_key;
      logic [VALUE_BITS-1:0] left_value, right_value;

      if (g == 0) begin : g_first
         assign left_lt    = 1'b1;
         assign left_key   = '0;
         assign left_value = '0;
      end else begin : g_inner
         assign left_lt    = lts[g-1];
         assign left_key   = keys[g-1];
         assign left_value = values[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign right_key   = '0;
         assign right_value = '0;
      end else begin : g_body
         assign right_key   = keys[g+1];
         assign right_value = values[g+1];
      end

      skvt_cell u_cell (
         .clock       (clock),
         .cell_index  (IDX_BITS'(g)),
         .acc         (acc),
         .cmd         (cmd),
         .left_lt     (left_lt),
         .left_key    (left_key),
         .left_value  (left_value),
         .right_key   (right_key),
         .right_value (right_value),
         .lt          (lts[g]),
         .key         (keys[g]),
         .value       (values[g]),
         .flags       (flags[g])
      );
   end

   skvt_collect u_collect (
      .flags      (flags),
      .keys       (keys),
      .values     (values),
      .last_lt    (lts[DEPTH-1]),
      .hit        (hit),
      .position   (position),
      .pick_key   (pick_key),
      .pick_value (pick_value)
   );

   always_comb begin
      status_in    = ST_OK;
      position_in  = position;
      out_key_in   = '0;
      out_value_in = '0;
      count_in     = count_ff;
      unique case (func_ff)
         FN_LOOKUP: begin
            if (hit) begin
               out_key_in   = pick_key;
               out_value_in = pick_value;
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         FN_UPDATE: begin
            if (!hit) begin
               status_in = ST_NOT_FOUND;
            end
         end
         FN_INSERT: begin
            priority if (hit) begin
               status_in = ST_PRESENT;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + POS_BITS'(1);
            end
         end
         FN_DELETE: begin
            if (hit) begin
               count_in = count_ff - POS_BITS'(1);
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         FN_READ: begin
            position_in = POS_BITS'(index_ff);
            if (read_ok) begin
               out_key_in   = pick_key;
               out_value_in = pick_value;
            end else begin
               status_in = ST_RANGE;
            end
         end
         default: begin
            position_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && !do_exec) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  func_ff  <= func_type'(req_tdata[FUNC_BITS-1:0]);
                  key_ff   <= req_tdata[KEY_LO +: KEY_BITS];
                  value_ff <= req_tdata[VAL_LO +: VALUE_BITS];
                  index_ff <= req_tdata[IDX_LO +: IDX_BITS];
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (do_exec) begin
                  count_ff     <= count_in;
                  status_ff    <= status_in;
                  position_ff  <= position_in;
                  out_key_ff   <= out_key_in;
                  out_value_ff <= out_value_in;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_BITS'({count_ff, out_value_ff, out_key_ff,
                                         position_ff, status_ff});

   `SKVT_ASSERT(a_count_bound, clock, reset, count_ff <= POS_BITS'(DEPTH), "count above depth")
   `SKVT_ASSERT_NEXT(a_take_exec, clock, reset, req_take, state_ff == S_EXEC, "request not executed")
   `SKVT_ASSERT(a_rsp_from_exec, clock, reset, $rose(rsp_valid_ff) |-> $past(do_exec), "response without execute")
   `SKVT_ASSERT_NEXT(a_insert_count, clock, reset, shift_up, count_ff == $past(count_ff) + POS_BITS'(1), "insert count mismatch")

endmodule

@@ verif/sorted_key_value_table_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the sorted key/value table: random requests against a table predictor.
module sorted_key_value_table_tb;
   import skvt_pkg::*;

   localparam logic [FUNC_BITS-1:0] FN_UNUSED_LO = 3'd5;
   localparam logic [FUNC_BITS-1:0] FN_UNUSED_HI = 3'd7;
   localparam int KEY_POOL_SIZE = 100;
   localparam int CALM_TAIL     = 150;
   localparam int HOLD_AT       = 300;
   localparam int LONG_HOLD     = 200;

   localparam int RSP_POS_LSB  = STAT_BITS;
   localparam int RSP_KEY_LSB  = RSP_POS_LSB + POS_BITS;
   localparam int RSP_VAL_LSB  = RSP_KEY_LSB + KEY_BITS;
   localparam int RSP_CNT_LSB  = RSP_VAL_LSB + VALUE_BITS;

   typedef struct {
      logic [FUNC_BITS-1:0]  func;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
      logic [IDX_BITS-1:0]   index;
   } table_req_type;

   typedef struct {
      status_type            status;
      logic [POS_BITS-1:0]   position;
      logic [KEY_BITS-1:0]   out_key;
      logic [VALUE_BITS-1:0] out_value;
      logic [POS_BITS-1:0]   count;
   } table_rsp_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;

   logic [KEY_BITS-1:0]   key_table [DEPTH];
   logic [VALUE_BITS-1:0] value_table [DEPTH];
   int                    entry_total = 0;

   logic [KEY_BITS-1:0] key_pool [KEY_POOL_SIZE];
   table_req_type       pending_requests [$];
   table_rsp_type       expected_responses [$];
   table_req_type       offered_request;
   int                  total_items = 0;
   int                  accepted_count = 0;
   int                  mismatch_count = 0;
   int                  send_gap = 0;
   int                  stall_left = 0;
   int                  taken_count = 0;
   bit                  long_hold_done = 1'b0;

   sorted_key_value_table i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predicts the response of one request and updates the table copy.
   function automatic table_rsp_type apply_request(table_req_type r);
      table_rsp_type res;
      int            slot;
      bit            hit;
      res.status    = ST_OK;
      res.position  = '0;
      res.out_key   = '0;
      res.out_value = '0;
      slot = 0;
      while (slot < entry_total && key_table[slot] < r.key)
         slot++;
      hit = (slot < entry_total) && (key_table[slot] == r.key);
      case (r.func)
         FN_LOOKUP: begin
            res.position = POS_BITS'(slot);
            if (hit) begin
               res.out_key   = key_table[slot];
               res.out_value = value_table[slot];
            end else
               res.status = ST_NOT_FOUND;
         end
         FN_UPDATE: begin
            res.position = POS_BITS'(slot);
            if (hit)
               value_table[slot] = r.value;
            else
               res.status = ST_NOT_FOUND;
         end
         FN_INSERT: begin
            res.position = POS_BITS'(slot);
            if (hit)
               res.status = ST_PRESENT;
            else if (entry_total >= DEPTH)
               res.status = ST_FULL;
            else begin
               for (int i = entry_total; i > slot; i--) begin
                  key_table[i]   = key_table[i-1];
                  value_table[i] = value_table[i-1];
               end
               key_table[slot]   = r.key;
               value_table[slot] = r.value;
               entry_total++;
            end
         end
         FN_DELETE: begin
            res.position = POS_BITS'(slot);
            if (hit) begin
               for (int i = slot; i + 1 < entry_total; i++) begin
                  key_table[i]   = key_table[i+1];
                  value_table[i] = value_table[i+1];
               end
               entry_total--;
            end else
               res.status = ST_NOT_FOUND;
         end
         FN_READ: begin
            res.position = POS_BITS'(r.index);
            if (r.index < entry_total) begin
               res.out_key   = key_table[r.index];
               res.out_value = value_table[r.index];
            end else
               res.status = ST_RANGE;
         end
         default: ;
      endcase
      res.count = POS_BITS'(entry_total);
      return res;
   endfunction

   function automatic void queue_request(logic [FUNC_BITS-1:0] f, logic [KEY_BITS-1:0] k,
                                         logic [VALUE_BITS-1:0] v, logic [IDX_BITS-1:0] i);
      table_req_type r;
      r.func  = f;
      r.key   = k;
      r.value = v;
      r.index = i;
      pending_requests.push_back(r);
   endfunction

   // Mostly keys from a small pool so that lookups, updates and deletes hit.
   function automatic void queue_random(int insert_pct, int delete_pct);
      logic [FUNC_BITS-1:0] f;
      logic [KEY_BITS-1:0]  k;
      int                   pick;
      pick = $urandom_range(0, 99);
      if (pick < insert_pct)
         f = FN_INSERT;
      else if (pick < insert_pct + delete_pct)
         f = FN_DELETE;
      else begin
         case ($urandom_range(0, 9))
            0, 1, 2: f = FN_LOOKUP;
            3, 4, 5: f = FN_UPDATE;
            6, 7, 8: f = FN_READ;
            default: f = FUNC_BITS'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
         endcase
      end
      if ($urandom_range(0, 99) < 85)
         k = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
      else
         k = KEY_BITS'($urandom_range(0, 65535));
      queue_request(f, k, VALUE_BITS'($urandom_range(0, 255)),
                    IDX_BITS'($urandom_range(0, DEPTH - 1)));
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_responses.push_back(apply_request(offered_request));
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 17);
               req_tvalid <= 1'b0;
            end else begin
               offered_request = pending_requests.pop_front();
               req_tdata  <= REQ_TDATA_BITS'({offered_request.index, offered_request.value,
                                              offered_request.key, offered_request.func});
               req_tvalid <= 1'b1;
            end
         end
      end
   end

   // Response back-pressure, with one long hold-off to fill the block
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            taken_count++;
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (taken_count == HOLD_AT && !long_hold_done) begin
            long_hold_done = 1'b1;
            stall_left = LONG_HOLD - 1;
            rsp_tready <= 1'b0;
         end else if (taken_count + CALM_TAIL < total_items && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 17);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Response checker
   always @(posedge clock) begin : rsp_check
      table_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_responses.size() == 0) begin
            $error("response with none expected");
            mismatch_count++;
         end else begin
            want = expected_responses.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_tdata[0 +: STAT_BITS]));
            check_field("position", 32'(want.position),
                        32'(rsp_tdata[RSP_POS_LSB +: POS_BITS]));
            check_field("out_key", 32'(want.out_key),
                        32'(rsp_tdata[RSP_KEY_LSB +: KEY_BITS]));
            check_field("out_value", 32'(want.out_value),
                        32'(rsp_tdata[RSP_VAL_LSB +: VALUE_BITS]));
            check_field("count", 32'(want.count), 32'(rsp_tdata[RSP_CNT_LSB +: POS_BITS]));
         end
      end
   end

   initial begin
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < KEY_POOL_SIZE; i++)
         key_pool[i] = KEY_BITS'($urandom_range(0, 65535));

      // empty table, edge keys, duplicate, middle and first deletes, range reads, unused codes
      queue_request(FN_READ,   16'h0000, 8'h00, 6'd0);
      queue_request(FN_LOOKUP, 16'h1234, 8'h00, 6'd0);
      queue_request(FN_UPDATE, 16'h1234, 8'h55, 6'd0);
      queue_request(FN_DELETE, 16'h1234, 8'h00, 6'd0);
      queue_request(FN_INSERT, 16'h8000, 8'hAA, 6'd0);
      queue_request(FN_INSERT, 16'h0000, 8'h00, 6'd0);
      queue_request(FN_INSERT, 16'hFFFF, 8'hFF, 6'd0);
      queue_request(FN_INSERT, 16'h8000, 8'h11, 6'd0);
      queue_request(FN_LOOKUP, 16'hFFFF, 8'h00, 6'd0);
      queue_request(FN_LOOKUP, 16'h0000, 8'h00, 6'd0);
      queue_request(FN_LOOKUP, 16'h7FFF, 8'h00, 6'd0);
      queue_request(FN_UPDATE, 16'h0000, 8'hFF, 6'd0);
      queue_request(FN_READ,   16'h0000, 8'h00, 6'd0);
      queue_request(FN_READ,   16'h0000, 8'h00, 6'd2);
      queue_request(FN_READ,   16'h0000, 8'h00, 6'd3);
      queue_request(FN_READ,   16'hFFFF, 8'hFF, 6'd63);
      queue_request(FN_DELETE, 16'h8000, 8'h00, 6'd0);
      queue_request(FN_DELETE, 16'h0000, 8'h00, 6'd0);
      queue_request(FN_READ,   16'h0000, 8'h00, 6'd0);
      for (int c = FN_UNUSED_LO; c <= FN_UNUSED_HI; c++)
         queue_request(FUNC_BITS'(c), 16'hFFFF, 8'hFF, 6'd63);
      queue_request(FN_DELETE, 16'hFFFF, 8'h00, 6'd0);

      // alternate filling (to full) and draining
      repeat (7) begin
         repeat (150) queue_random(75, 5);
         repeat (130) queue_random(10, 65);
      end
      total_items = pending_requests.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_items || expected_responses.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
